// ----- hw/rtl/lhmf_pkg.sv -----
// ----------------------------------------------------------------------------
// lhmf_pkg
// Shared constants, types and helpers for the length-header message fifo:
// store size, result codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lhmf_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int FILL_W       = 13;
  localparam int CNT_W        = 9;
  localparam int HEADER_BYTES = 4;

  localparam logic [2:0] ST_TAKEN  = 3'd0;
  localparam logic [2:0] ST_COMMIT = 3'd1;
  localparam logic [2:0] ST_DROP   = 3'd2;
  localparam logic [2:0] ST_BYTE   = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic push;        // push the accepted beat
    logic pop_empty;   // report empty on the accepted pop
    logic pop_read;    // issue the store read for the accepted pop
    logic pop_finish;  // store data is back, finish the pop
  } lhmf_cmd_t;

  typedef struct packed {
    logic empty;       // at a message start with nothing committed
  } lhmf_stat_t;

  function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
    next_addr = (a == ADDR_W'(BUFFER_BYTES - 1)) ? '0 : a + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/length_header_message_fifo.sv -----
// ----------------------------------------------------------------------------
// length_header_message_fifo
// Byte-wide circular message store with 4-byte length headers; messages are
// committed whole or dropped, and popped one byte per beat.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_ready    action, in_byte
//  out       out_valid / out_ready  status, out_byte, out_last, fill_level,
//                                   messages_in, messages_out
//
//  a push or empty pop result is registered in the cycle after accept; a pop
//  reads the byte store's registered read port, then registers the result
//  one beat is in flight at a time; the next is taken in the cycle its
//  predecessor's result is taken; unstalled, pushes run one beat a cycle
//  synchronous reset clears pointers, counters and fill; the store is not
//  cleared and needs no sweep after reset
//  a stalled result holds, and in_ready stays low until it is taken
`default_nettype none

module length_header_message_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          action,
  input  wire logic [7:0]                    in_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         status,
  output logic [7:0]                         out_byte,
  output logic                               out_last,
  output logic [lhmf_pkg::FILL_W-1:0]        fill_level,
  output logic [31:0]                        messages_in,
  output logic [31:0]                        messages_out
);
  import lhmf_pkg::*;

  lhmf_cmd_t  cmd;
  lhmf_stat_t stat;

  lhmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lhmf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_byte      (in_byte),
    .status       (status),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .fill_level   (fill_level),
    .messages_in  (messages_in),
    .messages_out (messages_out)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/lhmf_ctrl.sv -----
// ----------------------------------------------------------------------------
// lhmf_ctrl
// Handshake controller: accepts beats, sequences the pop through
// the store read and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lhmf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                action,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire lhmf_pkg::lhmf_stat_t stat,
  output lhmf_pkg::lhmf_cmd_t      cmd
);
  import lhmf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;
  logic state_next;
  logic acc;
  logic load;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.push       = acc && !action;
    cmd.pop_empty  = acc && action && stat.empty;
    cmd.pop_read   = acc && action && !stat.empty;
    cmd.pop_finish = (state == S_READ);
  end

  assign load = cmd.push || cmd.pop_empty || cmd.pop_finish;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.pop_read) state_next = S_READ;
      end
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lhmf_dp.sv -----
// ----------------------------------------------------------------------------
// lhmf_dp
// Datapath: byte store, write/read pointers, message framing counters,
// committed fill, message counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lhmf_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lhmf_pkg::lhmf_cmd_t  cmd,
  output lhmf_pkg::lhmf_stat_t      stat,
  input  wire logic [7:0]           in_byte,
  output logic [2:0]                status,
  output logic [7:0]                out_byte,
  output logic                      out_last,
  output logic [lhmf_pkg::FILL_W-1:0] fill_level,
  output logic [31:0]               messages_in,
  output logic [31:0]               messages_out
);
  import lhmf_pkg::*;

  localparam int SUM_W = FILL_W + 1;

  logic [7:0]        mem [BUFFER_BYTES];
  logic [7:0]        rd_data;

  logic [ADDR_W-1:0] write_pointer;
  logic [ADDR_W-1:0] write_start;
  logic [CNT_W-1:0]  push_count;
  logic [7:0]        push_payload_left;
  logic              push_overflow;
  logic [ADDR_W-1:0] read_pointer;
  logic [CNT_W-1:0]  pop_count;
  logic [7:0]        pop_payload_left;
  logic [FILL_W-1:0] committed_fill;
  logic [31:0]       in_counter;
  logic [31:0]       out_counter;

  // push side
  logic [SUM_W-1:0]  room_sum;
  logic              ovf_now;
  logic              push_last;
  logic [7:0]        push_left_next;
  logic [CNT_W-1:0]  push_len;

  // pop side
  logic              pop_last;
  logic [7:0]        pop_left_next;
  logic [CNT_W-1:0]  pop_len;
  logic [FILL_W-1:0] fill_after_pop;

  assign stat.empty = (pop_count == '0) && (committed_fill == '0);

  always_comb begin
    room_sum = SUM_W'(committed_fill) + SUM_W'(push_count) + SUM_W'(1);
    ovf_now  = push_overflow || (room_sum >= SUM_W'(BUFFER_BYTES));
    push_last      = 1'b0;
    push_left_next = push_payload_left;
    if (push_count == CNT_W'(HEADER_BYTES - 1)) begin
      push_left_next = in_byte;
      push_last      = (in_byte == 8'd0);
    end else if (push_count >= CNT_W'(HEADER_BYTES)) begin
      if (push_payload_left <= 8'd1) begin
        push_left_next = 8'd0;
        push_last      = 1'b1;
      end else begin
        push_left_next = push_payload_left - 8'd1;
      end
    end
    push_len = push_count + 1'b1;
  end

  always_comb begin
    pop_last      = 1'b0;
    pop_left_next = pop_payload_left;
    if (pop_count == CNT_W'(HEADER_BYTES - 1)) begin
      pop_left_next = rd_data;
      pop_last      = (rd_data == 8'd0);
    end else if (pop_count >= CNT_W'(HEADER_BYTES)) begin
      if (pop_payload_left <= 8'd1) begin
        pop_left_next = 8'd0;
        pop_last      = 1'b1;
      end else begin
        pop_left_next = pop_payload_left - 8'd1;
      end
    end
    pop_len        = pop_count + 1'b1;
    fill_after_pop = (committed_fill >= FILL_W'(pop_len)) ?
                     committed_fill - FILL_W'(pop_len) : '0;
  end

  // byte store, registered read
  always_ff @(posedge clk) begin
    if (cmd.push && !ovf_now) mem[write_pointer] <= in_byte;
    if (cmd.pop_read) rd_data <= mem[read_pointer];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer     <= '0;
      write_start       <= '0;
      push_count        <= '0;
      push_payload_left <= '0;
      push_overflow     <= 1'b0;
      read_pointer      <= '0;
      pop_count         <= '0;
      pop_payload_left  <= '0;
      committed_fill    <= '0;
      in_counter        <= '0;
      out_counter       <= '0;
    end else begin
      if (cmd.push) begin
        if (!push_last) begin
          write_pointer     <= next_addr(write_pointer);
          push_overflow     <= ovf_now;
          push_count        <= push_count + 1'b1;
          push_payload_left <= push_left_next;
        end else begin
          push_count        <= '0;
          push_payload_left <= '0;
          push_overflow     <= 1'b0;
          if (!ovf_now) begin
            // room was checked on every beat, so the message fits
            committed_fill <= committed_fill + FILL_W'(push_len);
            in_counter     <= in_counter + 32'd1;
            write_pointer  <= next_addr(write_pointer);
            write_start    <= next_addr(write_pointer);
          end else begin
            write_pointer <= write_start;
          end
        end
      end
      if (cmd.pop_read) read_pointer <= next_addr(read_pointer);
      if (cmd.pop_finish) begin
        if (pop_last) begin
          committed_fill   <= fill_after_pop;
          out_counter      <= out_counter + 32'd1;
          pop_count        <= '0;
          pop_payload_left <= '0;
        end else begin
          pop_count        <= pop_count + 1'b1;
          pop_payload_left <= pop_left_next;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      status   <= !push_last ? ST_TAKEN : (ovf_now ? ST_DROP : ST_COMMIT);
      out_byte <= 8'd0;
      out_last <= 1'b0;
    end else if (cmd.pop_empty) begin
      status   <= ST_EMPTY;
      out_byte <= 8'd0;
      out_last <= 1'b0;
    end else if (cmd.pop_finish) begin
      status   <= ST_BYTE;
      out_byte <= rd_data;
      out_last <= pop_last;
    end
  end

  // counters only move with a beat, so they hold while a result waits
  assign fill_level   = committed_fill;
  assign messages_in  = in_counter;
  assign messages_out = out_counter;

endmodule

`default_nettype wire
